[rtl/core/uv_sphere_vertex_generator_assert.svh]
// Assertion macros for the UV-sphere vertex generator.
// Included by modules that check their own pipeline; needs i_clk and i_rst_n in scope.
`ifndef UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication
`define UVS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UVS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/uvs_pkg.sv]
// Shared types and constants for the UV-sphere vertex generator.
// No dependencies.
package uvs_pkg;

    localparam int TURN_BITS       = 32;
    localparam int DIV_BITS_PER_ST = 4;
    localparam int CDC_STEPS       = 30;
    localparam int CDC_PER_ST      = 2;
    localparam int CDC_W           = 34;

    localparam logic signed [CDC_W-1:0] CDC_GAIN = 34'sd652032874;
    localparam logic [31:0]             PI_Q30   = 32'd3373259426;

    localparam logic signed [CDC_W-1:0] ATAN_Q30 [CDC_STEPS] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
        34'sd33543516,  34'sd16775851,  34'sd8388437,   34'sd4194283,   34'sd2097149,
        34'sd1048576,   34'sd524288,    34'sd262144,    34'sd131072,    34'sd65536,
        34'sd32768,     34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128,       34'sd64,
        34'sd32,        34'sd16,        34'sd8,         34'sd4,         34'sd2
    };

    typedef enum logic [1:0] {
        CFG_RADIUS = 2'd0,
        CFG_SLICES = 2'd1,
        CFG_STACKS = 2'd2
    } t_cfg_idx;

    typedef logic signed [CDC_W-1:0] t_cdc;

    typedef struct packed {
        t_cdc cos_v;
        t_cdc sin_v;
    } t_sincos;

endpackage

[rtl/core/uvs_div.sv]
// Pipelined restoring divider giving a 32-bit turn fraction, 4 quotient bits per stage.
// Depends on uvs_pkg.
module uvs_div
    import uvs_pkg::*;
#(
    parameter int IB = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [IB-1:0]     i_num,
    input  logic [IB:0]       i_den,
    input  logic [IB-1:0]     i_low,
    output logic              o_vld,
    output logic [TURN_BITS-1:0] o_quo
);

    localparam int RW = IB + 2;
    localparam int NS = TURN_BITS / DIV_BITS_PER_ST;

    logic [RW-1:0]        r_rem [NS];
    logic [TURN_BITS-1:0] r_quo [NS];
    logic [NS-1:0]        r_vld;
    logic [RW-1:0]        rem0;
    logic [RW-1:0]        den_w;
    logic [TURN_BITS-1:0] low_w;

    assign den_w = {1'b0, i_den};
    assign low_w = {{(TURN_BITS-IB){1'b0}}, i_low};
    assign rem0  = ({2'b00, i_num} >= den_w) ? ({2'b00, i_num} - den_w) : {2'b00, i_num};

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [RW-1:0]        src_rem;
        logic [TURN_BITS-1:0] src_quo;
        logic                 src_vld;
        logic [RW-1:0]        n_rem;
        logic [TURN_BITS-1:0] n_quo;

        if (s == 0) begin : g_first
            assign src_rem = rem0;
            assign src_quo = '0;
            assign src_vld = i_vld;
        end else begin : g_next
            assign src_rem = r_rem[s-1];
            assign src_quo = r_quo[s-1];
            assign src_vld = r_vld[s-1];
        end

        always_comb begin
            n_rem = src_rem;
            n_quo = src_quo;
            for (int b = 0; b < DIV_BITS_PER_ST; b++) begin
                n_rem = {n_rem[RW-2:0], low_w[TURN_BITS-1-(DIV_BITS_PER_ST*s+b)]};
                if (n_rem >= den_w) begin
                    n_rem = n_rem - den_w;
                    n_quo = {n_quo[TURN_BITS-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[TURN_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
            end
        end
    end

    assign o_vld = r_vld[NS-1];
    assign o_quo = r_quo[NS-1];

endmodule

[rtl/core/uvs_cordic.sv]
// Pipelined rotation CORDIC: turn fraction in, cosine and sine in Q3.30 out.
// Depends on uvs_pkg.
module uvs_cordic
    import uvs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [TURN_BITS-1:0] i_turn,
    output logic                 o_vld,
    output t_sincos              o_sc
);

    localparam int NS = CDC_STEPS / CDC_PER_ST;
    localparam int PB = 62;

    logic [PB-1:0] r_prod;
    logic [1:0]    r_qa;
    logic          r_va;
    t_cdc          r_z0;
    logic [1:0]    r_qb;
    logic          r_vb;
    logic [PB:0]   prod_rnd;

    t_cdc       r_x [NS];
    t_cdc       r_y [NS];
    t_cdc       r_z [NS];
    logic [1:0] r_q [NS];
    logic [NS-1:0] r_v;

    t_sincos r_sc;
    logic    r_vo;

    assign prod_rnd = {1'b0, r_prod} + (63'd1 << 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_vld;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PB'(i_turn[29:0] * PI_Q30);
            r_qa   <= i_turn[31:30];
            r_z0   <= CDC_W'(prod_rnd[PB:31]);
            r_qb   <= r_qa;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        t_cdc       src_x;
        t_cdc       src_y;
        t_cdc       src_z;
        logic [1:0] src_q;
        logic       src_v;
        t_cdc       n_x;
        t_cdc       n_y;
        t_cdc       n_z;

        if (s == 0) begin : g_first
            assign src_x = CDC_GAIN;
            assign src_y = '0;
            assign src_z = r_z0;
            assign src_q = r_qb;
            assign src_v = r_vb;
        end else begin : g_next
            assign src_x = r_x[s-1];
            assign src_y = r_y[s-1];
            assign src_z = r_z[s-1];
            assign src_q = r_q[s-1];
            assign src_v = r_v[s-1];
        end

        always_comb begin
            t_cdc tx;
            t_cdc ty;
            tx  = src_x;
            ty  = src_y;
            n_z = src_z;
            for (int b = 0; b < CDC_PER_ST; b++) begin
                if (!n_z[CDC_W-1]) begin
                    n_x = tx - (ty >>> (CDC_PER_ST*s+b));
                    n_y = ty + (tx >>> (CDC_PER_ST*s+b));
                    n_z = n_z - ATAN_Q30[CDC_PER_ST*s+b];
                end else begin
                    n_x = tx + (ty >>> (CDC_PER_ST*s+b));
                    n_y = ty - (tx >>> (CDC_PER_ST*s+b));
                    n_z = n_z + ATAN_Q30[CDC_PER_ST*s+b];
                end
                tx = n_x;
                ty = n_y;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s] <= n_x;
                r_y[s] <= n_y;
                r_z[s] <= n_z;
                r_q[s] <= src_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_q[NS-1])
                2'd0: begin
                    r_sc.cos_v <= r_x[NS-1];
                    r_sc.sin_v <= r_y[NS-1];
                end
                2'd1: begin
                    r_sc.cos_v <= -r_y[NS-1];
                    r_sc.sin_v <= r_x[NS-1];
                end
                2'd2: begin
                    r_sc.cos_v <= -r_x[NS-1];
                    r_sc.sin_v <= -r_y[NS-1];
                end
                2'd3: begin
                    r_sc.cos_v <= r_y[NS-1];
                    r_sc.sin_v <= -r_x[NS-1];
                end
            endcase
        end
    end

    assign o_vld = r_vo;
    assign o_sc  = r_sc;

endmodule

[rtl/core/uvs_proj.sv]
// Radius scaling, rounding and saturation of the three vertex coordinates.
// Depends on uvs_pkg.
module uvs_proj
    import uvs_pkg::*;
#(
    parameter int FB = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [14+FB-1:0]    i_radius,
    input  t_sincos             i_phi,
    input  t_sincos             i_theta,
    output logic                o_vld,
    output logic [15+FB-1:0]    o_pos_x,
    output logic [15+FB-1:0]    o_pos_y,
    output logic [15+FB-1:0]    o_pos_z
);

    localparam int RB = 14 + FB;
    localparam int OB = 15 + FB;
    localparam int PW = RB + 1 + CDC_W;
    localparam int MW = 2 * CDC_W;
    localparam int SW = 72;
    localparam logic signed [SW-1:0] OMAX = {{(SW-RB){1'b0}}, {RB{1'b1}}};

    function automatic logic [OB-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] res;
        if (v > OMAX) begin
            res = OMAX;
        end else if (v < -OMAX) begin
            res = -OMAX;
        end else begin
            res = v;
        end
        return res[OB-1:0];
    endfunction

    logic signed [PW-1:0] r_py_p;
    logic signed [PW-1:0] r_pm_p;
    t_cdc                 r_ct1;
    t_cdc                 r_st1;
    t_cdc                 r_m;
    logic [OB-1:0]        r_y2;
    t_cdc                 r_ct2;
    t_cdc                 r_st2;
    logic signed [MW-1:0] r_px_p;
    logic signed [MW-1:0] r_pz_p;
    logic [OB-1:0]        r_y3;
    logic [OB-1:0]        r_x4;
    logic [OB-1:0]        r_y4;
    logic [OB-1:0]        r_z4;
    logic [3:0]           r_v;

    logic signed [SW-1:0] py_w;
    logic signed [SW-1:0] pm_w;
    logic signed [SW-1:0] px_w;
    logic signed [SW-1:0] pz_w;
    logic signed [SW-1:0] y_rnd;
    logic signed [SW-1:0] m_rnd;
    logic signed [SW-1:0] x_rnd;
    logic signed [SW-1:0] z_rnd;
    logic signed [RB:0]   rad_s;

    assign rad_s = {1'b0, i_radius};
    assign py_w  = {{(SW-PW){r_py_p[PW-1]}}, r_py_p};
    assign pm_w  = {{(SW-PW){r_pm_p[PW-1]}}, r_pm_p};
    assign px_w  = {{(SW-MW){r_px_p[MW-1]}}, r_px_p};
    assign pz_w  = {{(SW-MW){r_pz_p[MW-1]}}, r_pz_p};
    assign y_rnd = (py_w + (SW'(1) <<< 29)) >>> 30;
    assign m_rnd = (pm_w + (SW'(1) <<< (11 + FB))) >>> (12 + FB);
    assign x_rnd = (px_w + (SW'(1) <<< (47 - FB))) >>> (48 - FB);
    assign z_rnd = (pz_w + (SW'(1) <<< (47 - FB))) >>> (48 - FB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_py_p <= PW'(rad_s) * PW'(i_phi.cos_v);
            r_pm_p <= PW'(rad_s) * PW'(i_phi.sin_v);
            r_ct1  <= i_theta.cos_v;
            r_st1  <= i_theta.sin_v;
            r_m    <= m_rnd[CDC_W-1:0];
            r_y2   <= sat(y_rnd);
            r_ct2  <= r_ct1;
            r_st2  <= r_st1;
            r_px_p <= MW'(r_m) * MW'(r_ct2);
            r_pz_p <= MW'(r_m) * MW'(r_st2);
            r_y3   <= r_y2;
            r_x4   <= sat(x_rnd);
            r_y4   <= r_y3;
            r_z4   <= sat(z_rnd);
        end
    end

    assign o_vld   = r_v[3];
    assign o_pos_x = r_x4;
    assign o_pos_y = r_y4;
    assign o_pos_z = r_z4;

endmodule

[rtl/core/uv_sphere_vertex_generator.sv]
// Channel | Direction | Signals
// in      | to block  | i_valid, o_stall, i_stack_index, i_slice_index
// out     | from block| o_valid, i_stall, o_pos_x, o_pos_y, o_pos_z
// cfg     | to block  | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
// One item per cycle while the output is not held. It has an input register,
// 8 divider stages, 18 CORDIC stages and 4 scaling stages. Reset is synchronous,
// active low, and clears valid bits and restores configuration defaults. A held
// output freezes the whole pipeline; otherwise bubbles flow through. Depends on
// uvs_pkg, uvs_div, uvs_cordic, uvs_proj and the assert header.
`include "uv_sphere_vertex_generator_assert.svh"

module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int INDEX_BITS = 8,
    parameter int FRAC_BITS  = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [INDEX_BITS-1:0]   i_stack_index,
    input  logic [INDEX_BITS-1:0]   i_slice_index,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [15+FRAC_BITS-1:0] o_pos_x,
    output logic signed [15+FRAC_BITS-1:0] o_pos_y,
    output logic signed [15+FRAC_BITS-1:0] o_pos_z,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [14+FRAC_BITS-1:0] i_cfg_data
);

    localparam int RB = 14 + FRAC_BITS;
    localparam int OB = 15 + FRAC_BITS;
    localparam int IB = INDEX_BITS;

    logic [RB-1:0] r_radius;
    logic [IB-1:0] r_slices;
    logic [IB-1:0] r_stacks;
    logic [IB-1:0] r_i;
    logic [IB-1:0] r_j;
    logic          r_v0;

    logic          en;
    logic [IB-1:0] stacks_e;
    logic [IB-1:0] slices_e;
    logic [IB-1:0] n_i;
    logic [IB-1:0] n_j;

    logic                 phi_vld;
    logic                 theta_vld;
    logic [TURN_BITS-1:0] phi_turn;
    logic [TURN_BITS-1:0] theta_turn;
    logic                 phi_sc_vld;
    logic                 theta_sc_vld;
    t_sincos              phi_sc;
    t_sincos              theta_sc;
    logic [OB-1:0]        pos_x;
    logic [OB-1:0]        pos_y;
    logic [OB-1:0]        pos_z;

    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    assign stacks_e = (r_stacks == '0) ? IB'(1) : r_stacks;
    assign slices_e = (r_slices == '0) ? IB'(1) : r_slices;
    assign n_i      = (i_stack_index > stacks_e) ? stacks_e : i_stack_index;
    assign n_j      = (i_slice_index > slices_e) ? slices_e : i_slice_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RB'(1024);
            r_slices <= IB'(10);
            r_stacks <= IB'(10);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIUS: r_radius <= i_cfg_data;
                CFG_SLICES: r_slices <= i_cfg_data[IB-1:0];
                CFG_STACKS: r_stacks <= i_cfg_data[IB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i <= n_i;
            r_j <= n_j;
        end
    end

    uvs_div #(.IB(IB)) u_div_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v0),
        .i_num   (r_i),
        .i_den   ({stacks_e, 1'b0}),
        .i_low   (stacks_e),
        .o_vld   (phi_vld),
        .o_quo   (phi_turn)
    );

    uvs_div #(.IB(IB)) u_div_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v0),
        .i_num   (r_j),
        .i_den   ({1'b0, slices_e}),
        .i_low   (slices_e >> 1),
        .o_vld   (theta_vld),
        .o_quo   (theta_turn)
    );

    uvs_cordic u_cdc_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (phi_vld),
        .i_turn  (phi_turn),
        .o_vld   (phi_sc_vld),
        .o_sc    (phi_sc)
    );

    uvs_cordic u_cdc_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (theta_vld),
        .i_turn  (theta_turn),
        .o_vld   (theta_sc_vld),
        .o_sc    (theta_sc)
    );

    uvs_proj #(.FB(FRAC_BITS)) u_proj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (phi_sc_vld),
        .i_radius (r_radius),
        .i_phi    (phi_sc),
        .i_theta  (theta_sc),
        .o_vld    (o_valid),
        .o_pos_x  (pos_x),
        .o_pos_y  (pos_y),
        .o_pos_z  (pos_z)
    );

    assign o_pos_x = pos_x;
    assign o_pos_y = pos_y;
    assign o_pos_z = pos_z;

    `UVS_ASSERT_IMP(a_lanes_aligned, 1'b1, phi_sc_vld == theta_sc_vld, "angle lanes out of step")
    `UVS_ASSERT_IMP(a_stall_only_held, o_stall, o_valid && i_stall, "stall without held item")
    `UVS_ASSERT_NXT(a_accept_enters, i_valid && !o_stall, r_v0, "accepted item lost at entry")
    `UVS_ASSERT_IMP(a_sat_x, o_valid, o_pos_x != {1'b1, {(OB-1){1'b0}}}, "x beyond saturation")
    `UVS_ASSERT_IMP(a_sat_y, o_valid, o_pos_y != {1'b1, {(OB-1){1'b0}}}, "y beyond saturation")

endmodule

[test/uv_sphere_vertex_generator_tb.sv]
// Self-checking testbench for uv_sphere_vertex_generator: streams grid points under random
// idling, predicts each vertex with a bit-exact CORDIC model and checks every field.
// Depends on uvs_pkg and the RTL of the block.
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_tb;
    import uvs_pkg::*;

    localparam int IDX_W  = 8;
    localparam int FRAC_W = 10;
    localparam int OUT_W  = 15 + FRAC_W;
    localparam int RAD_W  = 14 + FRAC_W;
    localparam int LATENCY = 31;
    localparam int LIMIT   = 400000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam longint OUT_MAX = (64'sd1 <<< RAD_W) - 1;

    typedef struct {
        logic [IDX_W-1:0] stack_idx;
        logic [IDX_W-1:0] slice_idx;
    } t_point;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_vertex;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [IDX_W-1:0]        i_stack_index = '0;
    logic [IDX_W-1:0]        i_slice_index = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_pos_x;
    logic signed [OUT_W-1:0] o_pos_y;
    logic signed [OUT_W-1:0] o_pos_z;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index = '0;
    logic [RAD_W-1:0]        i_cfg_data = '0;

    t_point  pending_points[$];
    t_vertex expected_vertices[$];
    logic [RAD_W-1:0] radius_q = 24'd1024;
    logic [IDX_W-1:0] slices_q = 8'd10;
    logic [IDX_W-1:0] stacks_q = 8'd10;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;
    int  fails = 0;
    int  cycles = 0;

    uv_sphere_vertex_generator dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void turn_sincos(input logic [31:0] turn, output longint c,
                                        output longint s);
        longint unsigned t;
        longint x, y, z, nx, ny;
        t = turn[29:0];
        x = CDC_GAIN;
        y = 0;
        z = longint'((t * longint'(PI_Q30) + (64'd1 << 30)) >> 31);
        for (int k = 0; k < CDC_STEPS; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                ny = y + (x >>> k);
                z -= longint'(ATAN_Q30[k]);
            end else begin
                nx = x + (y >>> k);
                ny = y - (x >>> k);
                z += longint'(ATAN_Q30[k]);
            end
            x = nx;
            y = ny;
        end
        case (turn[31:30])
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint round_sh(input longint v, input int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic logic signed [OUT_W-1:0] clip(input longint v);
        if (v > OUT_MAX) v = OUT_MAX;
        if (v < -OUT_MAX) v = -OUT_MAX;
        return v[OUT_W-1:0];
    endfunction

    function automatic t_vertex vertex_of(input t_point p);
        longint unsigned st, sl, i, j;
        logic [31:0] phi_turn, theta_turn;
        longint cp, sp, ct, sn, r, m;
        t_vertex v;
        st = (stacks_q == 0) ? 1 : stacks_q;
        sl = (slices_q == 0) ? 1 : slices_q;
        i = (p.stack_idx > st) ? st : p.stack_idx;
        j = (p.slice_idx > sl) ? sl : p.slice_idx;
        phi_turn = 32'(((i << 32) + st) / (2 * st));
        theta_turn = 32'(((j << 32) + (sl >> 1)) / sl);
        turn_sincos(phi_turn, cp, sp);
        turn_sincos(theta_turn, ct, sn);
        r = longint'(radius_q);
        m = round_sh(r * sp, 12 + FRAC_W);
        v.x = clip(round_sh(m * ct, 48 - FRAC_W));
        v.y = clip(round_sh(r * cp, 30));
        v.z = clip(round_sh(m * sn, 48 - FRAC_W));
        return v;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_point p;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                p.stack_idx = i_stack_index;
                p.slice_idx = i_slice_index;
                expected_vertices = {expected_vertices, vertex_of(p)};
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    p = pending_points.pop_front();
                    i_valid <= 1'b1;
                    i_stack_index <= p.stack_idx;
                    i_slice_index <= p.slice_idx;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 14);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_seen = 1'b0;
    always @(posedge i_clk) begin
        t_vertex e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_vertices.size() == 0) begin
                    $error("unexpected vertex x=%0d y=%0d z=%0d", o_pos_x, o_pos_y, o_pos_z);
                    fails++;
                end else begin
                    e = expected_vertices.pop_front();
                    if (o_pos_x !== e.x) begin
                        $error("pos_x expected %0d got %0d", e.x, o_pos_x);
                        fails++;
                    end
                    if (o_pos_y !== e.y) begin
                        $error("pos_y expected %0d got %0d", e.y, o_pos_y);
                        fails++;
                    end
                    if (o_pos_z !== e.z) begin
                        $error("pos_z expected %0d got %0d", e.z, o_pos_z);
                        fails++;
                    end
                end
            end
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 13);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic add_point(input int s, input int l);
        t_point p;
        p.stack_idx = IDX_W'(s);
        p.slice_idx = IDX_W'(l);
        pending_points = {pending_points, p};
    endtask

    task automatic add_random_points(input int n);
        int st, sl;
        st = (stacks_q == 0) ? 1 : stacks_q;
        sl = (slices_q == 0) ? 1 : slices_q;
        repeat (n) begin
            if ($urandom_range(0, 7) == 0)
                add_point($urandom_range(0, 255), $urandom_range(0, 255));
            else
                add_point($urandom_range(0, st), $urandom_range(0, sl));
        end
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending_points.size() > 0 || i_valid || expected_vertices.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [RAD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIUS: radius_q = data;
            CFG_SLICES: slices_q = data[IDX_W-1:0];
            CFG_STACKS: stacks_q = data[IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_sphere(input logic [RAD_W-1:0] r, input int sl, input int st);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_SLICES, RAD_W'(sl));
        write_reg(CFG_STACKS, RAD_W'(st));
        @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // poles, equator, full turn, clamped and extreme indices at reset settings
        add_point(0, 0);
        add_point(10, 10);
        add_point(5, 0);
        add_point(5, 5);
        add_point(5, 10);
        add_point(255, 255);
        add_point(11, 11);
        add_point(0, 255);
        add_point(255, 0);
        add_point(3, 7);
        add_point(8'hAA, 8'h55);
        add_point(8'h55, 8'hAA);
        drain();

        set_sphere(24'hFFFFFF, 255, 255);
        add_point(0, 0);
        add_point(127, 64);
        add_point(128, 191);
        add_point(255, 255);
        add_point(200, 100);
        drain();

        set_sphere(24'd0, 1, 1);
        add_point(1, 1);
        add_point(0, 0);
        drain();

        // zero counts act as one; unused register index is dropped
        set_sphere(24'd2048, 0, 0);
        write_reg(CFG_UNUSED, 24'h123456);
        add_point(1, 0);
        add_point(2, 1);
        add_point(0, 3);
        add_point(1, 1);
        drain();

        set_sphere(24'd1, 4, 2);
        add_random_points(60);
        drain();

        set_sphere(24'd1024, 16, 8);
        hold_req = 1'b1;
        add_random_points(150);
        drain();

        repeat (6) begin
            set_sphere($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 255),
                       $urandom_range(0, 255));
            add_random_points(50);
            drain();
        end

        idle_on = 1'b0;
        set_sphere($urandom_range(0, 24'hFFFFFF), $urandom_range(1, 255),
                   $urandom_range(1, 255));
        add_random_points(90);
        drain();

        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/uvs_pkg.sv
rtl/core/uvs_div.sv
rtl/core/uvs_cordic.sv
rtl/core/uvs_proj.sv
rtl/core/uv_sphere_vertex_generator.sv
test/uv_sphere_vertex_generator_tb.sv
